/* hw/rtl/ilxdc_pkg.sv */
// ----------------------------------------------------------------------------
// ilxdc_pkg
// Shared types and constants of the I2S left-channel extractor with DC blocker.
// ----------------------------------------------------------------------------
`default_nettype none

package ilxdc_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_HALFWORDS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_Q24        = 1'd1;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [15:0] BUFFER_HALFWORDS_RESET = 16'd4096;
   localparam logic [23:0] ALPHA_Q24_RESET        = 24'd16773861;

   // Filter accumulator and intermediate widths
   localparam int unsigned ACC_W  = 40;
   localparam int unsigned HALF_W = ACC_W / 2;
   localparam int unsigned PP_W   = HALF_W + 24;
   localparam int unsigned PROD_W = ACC_W + 24;
   localparam int unsigned SUM_W  = PROD_W + 2;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic [15:0] SAMPLE_MAX  = 16'h7FFF;
   localparam logic [15:0] SAMPLE_MIN  = 16'h8000;
   localparam logic [ACC_W-1:0] MAG_POS_LIMIT = ACC_W'(32767);
   localparam logic [ACC_W-1:0] MAG_NEG_LIMIT = ACC_W'(32768);

   // One beat leaving the alignment stage
   typedef struct packed {
      logic               take;
      logic               restart;
      logic               last;
      logic signed [15:0] x;
   } smp_type;

   // One filtered result
   typedef struct packed {
      logic        last;
      logic [15:0] sample;
   } res_type;

endpackage

`default_nettype wire

/* hw/rtl/i2s_left_extract_dc_blocker.sv */
// ----------------------------------------------------------------------------
// i2s_left_extract_dc_blocker
// Left sample extraction from raw I2S halfwords with a DC blocking filter.
// ----------------------------------------------------------------------------
// One halfword beat is accepted per clock while the pipeline has room. A beat
// passes three registers: the alignment stage, the feedback multiply (|y| *
// alpha split into two 20x24 partial products) and the accumulate/saturate
// stage that loads the result register. Samples of a buffer are at least two
// beats apart, which lets the filter history settle between them with no
// stall. Backpressure on rsp_ holds the result register, and a combinational
// ready chain stalls the full stages behind it; req_ keeps taking beats while
// a stage has room. Write csr_ registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2s_left_extract_dc_blocker #(
   parameter int unsigned COEF_FRAC_BITS = 24,
   parameter int unsigned ACC_FRAC_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic [0:0]  csr_index,
   input  wire logic [23:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] halfword
   input  wire logic [1:0]  req_tuser,   // [0] buffer_start, [1] restart
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] sample
   output logic             rsp_tlast    // last_in_buffer
);

   logic [15:0] buf_hw_ff;
   logic [23:0] alpha_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff;
   logic        rsp_last_ff;

   logic               s1_valid, s1_ready;
   ilxdc_pkg::smp_type s1_beat;
   logic               res_valid, res_ready;
   ilxdc_pkg::res_type res_beat;
   logic               s2_take_busy;
   logic               out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_hw_ff <= ilxdc_pkg::BUFFER_HALFWORDS_RESET;
         alpha_ff  <= ilxdc_pkg::ALPHA_Q24_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            ilxdc_pkg::CSR_BUFFER_HALFWORDS: buf_hw_ff <= csr_wdata[15:0];
            ilxdc_pkg::CSR_ALPHA_Q24:        alpha_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   ilxdc_align u_align (
      .clock            (clock),
      .reset            (reset),
      .buffer_halfwords (buf_hw_ff),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .s1_valid         (s1_valid),
      .s1_ready         (s1_ready),
      .s1_beat          (s1_beat)
   );

   ilxdc_filter #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .ACC_FRAC_BITS  (ACC_FRAC_BITS)
   ) u_filter (
      .clock        (clock),
      .reset        (reset),
      .alpha_q24    (alpha_ff),
      .s1_valid     (s1_valid),
      .s1_ready     (s1_ready),
      .s1_beat      (s1_beat),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_beat     (res_beat),
      .s2_take_busy (s2_take_busy)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;
   assign out_load  = res_valid && res_ready;

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= res_beat.sample;
         rsp_last_ff <= res_beat.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // two samples never sit in adjacent stages; the feedback relies on it
   a_no_adjacent_samples: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && s1_beat.take) |-> !s2_take_busy)
      else $error("sample in alignment stage while filter stage holds a sample");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid |-> req_tready)
      else $error("input stalled with empty alignment stage");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_tvalid && rsp_tlast == $past(res_beat.last)))
      else $error("filtered sample not presented after load");

endmodule

`default_nettype wire

/* hw/rtl/ilxdc_align.sv */
// ----------------------------------------------------------------------------
// ilxdc_align
// Buffer position tracking, alignment offset choice and left sample pick.
// ----------------------------------------------------------------------------
`default_nettype none

module ilxdc_align (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [15:0]         buffer_halfwords,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [15:0]         req_tdata,   // [15:0] halfword
   input  wire logic [1:0]          req_tuser,   // [0] buffer_start, [1] restart
   output logic                     s1_valid,
   input  wire logic                s1_ready,
   output ilxdc_pkg::smp_type       s1_beat
);

   logic [15:0]        pos_ff, pos_in;
   logic [1:0]         off_ff, off_in;
   logic [13:0]        taken_ff, taken_in;
   logic [13:0]        limit_ff, limit_in;
   logic [15:0]        first_ff, first_in;
   logic               s1_valid_ff, s1_valid_in;
   ilxdc_pkg::smp_type s1_beat_ff, s1_beat_in;

   logic        accept;
   logic [15:0] p;
   logic        in_range;
   logic [1:0]  off_new;
   logic [2:0]  need;
   logic [15:0] room;
   logic [13:0] limit_calc;
   logic        cand;
   logic [15:0] value;
   logic        take;

   assign req_tready = !s1_valid_ff || s1_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      p        = req_tuser[0] ? 16'd0 : pos_ff;
      pos_in   = pos_ff;
      off_in   = off_ff;
      taken_in = taken_ff;
      limit_in = limit_ff;
      first_in = first_ff;
      in_range = p < buffer_halfwords;

      // offset and end trim from the first two halfwords
      if (first_ff == 16'd0 && req_tdata != 16'd0) begin
         off_new = 2'd1;
         need    = 3'd2;
      end else if (first_ff == 16'd0) begin
         off_new = 2'd2;
         need    = 3'd2;
      end else if (req_tdata == 16'd0) begin
         off_new = 2'd3;
         need    = 3'd4;
      end else begin
         off_new = 2'd0;
         need    = 3'd0;
      end
      room       = buffer_halfwords - 16'(need);
      limit_calc = (buffer_halfwords >= 16'(need)) ? room[15:2] : 14'd0;

      cand  = 1'b0;
      value = req_tdata;
      if (p == 16'd1) begin
         if (off_new == 2'd0) begin
            cand  = 1'b1;
            value = first_ff;
         end else if (off_new == 2'd1) begin
            cand = 1'b1;
         end
      end else if (p >= 16'd2 && p[1:0] == off_ff) begin
         cand = 1'b1;
      end

      if (p == 16'd1) begin
         limit_in = limit_calc;
      end
      take = in_range && cand && (taken_ff < limit_in);

      if (accept) begin
         pos_in = (p != 16'hFFFF) ? p + 16'd1 : p;
         if (in_range) begin
            if (p == 16'd0) begin
               first_in = req_tdata;
               taken_in = 14'd0;
               limit_in = 14'd0;
               off_in   = 2'd0;
            end else if (p == 16'd1) begin
               off_in = off_new;
            end
            if (take) begin
               taken_in = taken_ff + 14'd1;
            end
         end
      end else begin
         limit_in = limit_ff;
      end

      s1_beat_in.take    = take;
      s1_beat_in.restart = req_tuser[1];
      s1_beat_in.last    = (taken_ff + 14'd1) == limit_in;
      s1_beat_in.x       = $signed(value);

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         off_ff      <= '0;
         taken_ff    <= '0;
         limit_ff    <= '0;
         first_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         off_ff      <= off_in;
         taken_ff    <= taken_in;
         limit_ff    <= limit_in;
         first_ff    <= first_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_beat_ff <= s1_beat_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_beat  = s1_beat_ff;

endmodule

`default_nettype wire

/* hw/rtl/ilxdc_filter.sv */
// ----------------------------------------------------------------------------
// ilxdc_filter
// DC blocker: split feedback multiply, then accumulate, saturate and truncate toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ilxdc_filter #(
   parameter int unsigned COEF_FRAC_BITS = 24,
   parameter int unsigned ACC_FRAC_BITS  = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [23:0]         alpha_q24,
   input  wire logic                s1_valid,
   output logic                     s1_ready,
   input  wire ilxdc_pkg::smp_type  s1_beat,
   output logic                     res_valid,
   input  wire logic                res_ready,
   output ilxdc_pkg::res_type       res_beat,
   output logic                     s2_take_busy
);

   localparam int unsigned ACC_W  = ilxdc_pkg::ACC_W;
   localparam int unsigned HALF_W = ilxdc_pkg::HALF_W;
   localparam int unsigned PP_W   = ilxdc_pkg::PP_W;
   localparam int unsigned PROD_W = ilxdc_pkg::PROD_W;
   localparam int unsigned SUM_W  = ilxdc_pkg::SUM_W;

   logic signed [15:0]      prev_ff, prev_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_take_ff;
   logic                    s2_last_ff;
   logic [PP_W-1:0]         pp_hi_ff, pp_lo_ff;
   logic                    neg_ff;
   logic signed [16:0]      diff_ff;

   logic                    s2_advance;
   logic                    s1_move;
   logic signed [ACC_W-1:0] y;
   logic signed [15:0]      px;
   logic [ACC_W-1:0]        mag;
   logic [PROD_W-1:0]       prod;
   logic [PROD_W-1:0]       fb;
   logic signed [SUM_W-1:0] sdiff, sfb, sum;
   logic signed [ACC_W-1:0] acc_new;
   logic [ACC_W-1:0]        amag, ipart;
   logic [15:0]             sample;

   assign s2_advance = s2_valid_ff && (!s2_take_ff || res_ready);
   assign s1_ready   = !s2_valid_ff || s2_advance;
   assign s1_move    = s1_valid && s1_ready;

   // first half: history select and the two partial products of |y| * alpha
   always_comb begin
      y   = s1_beat.restart ? '0 : acc_ff;
      px  = s1_beat.restart ? '0 : prev_ff;
      mag = y[ACC_W-1] ? ACC_W'(-y) : ACC_W'(y);
   end

   // second half: recombine, accumulate, saturate, truncate toward zero
   always_comb begin
      prod  = {pp_hi_ff, {HALF_W{1'b0}}} + PROD_W'(pp_lo_ff);
      fb    = prod >> COEF_FRAC_BITS;
      sdiff = SUM_W'(diff_ff) <<< ACC_FRAC_BITS;
      sfb   = $signed({2'b00, fb});
      sum   = neg_ff ? sdiff - sfb : sdiff + sfb;
      if (sum > SUM_W'(ilxdc_pkg::ACC_MAX)) begin
         acc_new = ilxdc_pkg::ACC_MAX;
      end else if (sum < SUM_W'(ilxdc_pkg::ACC_MIN)) begin
         acc_new = ilxdc_pkg::ACC_MIN;
      end else begin
         acc_new = ACC_W'(sum);
      end
      amag  = acc_new[ACC_W-1] ? ACC_W'(-acc_new) : ACC_W'(acc_new);
      ipart = amag >> ACC_FRAC_BITS;
      if (!acc_new[ACC_W-1]) begin
         sample = (ipart > ilxdc_pkg::MAG_POS_LIMIT) ? ilxdc_pkg::SAMPLE_MAX : ipart[15:0];
      end else begin
         sample = (ipart > ilxdc_pkg::MAG_NEG_LIMIT) ? ilxdc_pkg::SAMPLE_MIN
                                                     : 16'(-ipart[15:0]);
      end
   end

   always_comb begin
      prev_in = prev_ff;
      acc_in  = acc_ff;
      if (s2_advance && s2_take_ff) begin
         acc_in = acc_new;
      end
      // a restart behind the retiring sample clears after it
      if (s1_move && s1_beat.restart) begin
         acc_in  = '0;
         prev_in = '0;
      end
      if (s1_move && s1_beat.take) begin
         prev_in = s1_beat.x;
      end

      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (s2_advance) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         acc_ff      <= '0;
         s2_valid_ff <= 1'b0;
         s2_take_ff  <= 1'b0;
      end else begin
         prev_ff     <= prev_in;
         acc_ff      <= acc_in;
         s2_valid_ff <= s2_valid_in;
         if (s1_move) begin
            s2_take_ff <= s1_beat.take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_last_ff <= s1_beat.last;
         pp_hi_ff   <= PP_W'(mag[ACC_W-1:HALF_W]) * PP_W'(alpha_q24);
         pp_lo_ff   <= PP_W'(mag[HALF_W-1:0]) * PP_W'(alpha_q24);
         neg_ff     <= y[ACC_W-1];
         diff_ff    <= {s1_beat.x[15], s1_beat.x} - {px[15], px};
      end
   end

   assign res_valid       = s2_valid_ff && s2_take_ff;
   assign res_beat.sample = sample;
   assign res_beat.last   = s2_last_ff;
   assign s2_take_busy    = s2_valid_ff && s2_take_ff;

endmodule

`default_nettype wire

/* tb/i2s_left_extract_dc_blocker_tb.sv */
// ----------------------------------------------------------------------------
// i2s_left_extract_dc_blocker_tb
// Self-checking bench for the left-sample extractor with DC blocker.
// ----------------------------------------------------------------------------
// Raw halfword beats go in on req_, and a bit-true predictor of the alignment
// choice, the per-buffer sample count and the Q24.16 filter queues the samples
// that must come out on rsp_. Directed tests cover the four alignment cases,
// power-on items, a buffer resize mid-buffer and the largest buffer length.
// Random buffers then run under several register settings and idle/stall
// patterns.
// ----------------------------------------------------------------------------
module i2s_left_extract_dc_blocker_tb;

   localparam int CLK_PERIOD = 12;
   localparam int RUN_LIMIT_CYCLES = 1_000_000;
   localparam int SETTLE_CYCLES = 10;
   localparam longint ACC_TOP = 64'sd549755813887;
   localparam longint ACC_BOTTOM = -ACC_TOP - 1;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_wen = 1'b0;
   logic [ilxdc_pkg::CSR_INDEX_W-1:0] csr_index = ilxdc_pkg::CSR_BUFFER_HALFWORDS;
   logic [ilxdc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [15:0]                       req_tdata = '0;   // [15:0] halfword
   logic [1:0]                        req_tuser = '0;   // [0] buffer_start, [1] restart
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [15:0]                       rsp_tdata;        // [15:0] sample
   logic                              rsp_tlast;

   // Predictor state
   logic [15:0]        cfg_len = ilxdc_pkg::BUFFER_HALFWORDS_RESET;
   logic [23:0]        cfg_alpha = ilxdc_pkg::ALPHA_Q24_RESET;
   logic signed [15:0] prev_in = '0;
   logic signed [39:0] acc_y = '0;
   logic [15:0]        pos = '0;
   logic [1:0]         align_off = '0;
   logic [13:0]        taken = '0;
   logic [13:0]        limit = '0;
   logic [15:0]        first_hw = '0;

   ilxdc_pkg::res_type left_samples_due[$];
   ilxdc_pkg::res_type due_sample;
   int      fault_count = 0;
   int      beats_sent = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;

   i2s_left_extract_dc_blocker dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * RUN_LIMIT_CYCLES);
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (left_samples_due.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected sample %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            due_sample = left_samples_due.pop_front();
            if (rsp_tdata !== due_sample.sample || rsp_tlast !== due_sample.last) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("sample mismatch: want %h last %b, got %h last %b",
                           due_sample.sample, due_sample.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // Advance buffer position, pick alignment, run the DC blocker on picked samples.
   task automatic extract_and_filter(input logic [15:0] hw, input logic start,
                                     input logic rst);
      logic [15:0]        p;
      logic [15:0]        val;
      logic               take;
      int                 off;
      int                 tail;
      int                 room;
      logic signed [63:0] x64;
      logic signed [63:0] prev64;
      logic signed [63:0] y64;
      logic signed [63:0] acc64;
      logic signed [63:0] out64;
      logic [63:0]        mag;
      logic [63:0]        fb;
      ilxdc_pkg::res_type item;

      if (rst) begin
         prev_in = '0;
         acc_y = '0;
      end
      p = start ? 16'd0 : pos;
      pos = (p != 16'hFFFF) ? p + 16'd1 : 16'hFFFF;
      if (p >= cfg_len) return;
      if (p == 16'd0) begin
         first_hw = hw;
         taken = '0;
         limit = '0;
         align_off = '0;
         return;
      end
      take = 1'b0;
      val = hw;
      if (p == 16'd1) begin
         if (first_hw == 16'd0 && hw != 16'd0) begin
            off = 1; tail = 1;
         end else if (first_hw == 16'd0) begin
            off = 2; tail = 0;
         end else if (hw == 16'd0) begin
            off = 3; tail = 1;
         end else begin
            off = 0; tail = 0;
         end
         align_off = off[1:0];
         room = int'(cfg_len) - off - tail;
         limit = (room >= 0) ? 14'(room >>> 2) : 14'd0;
         // Offset zero emits the sample held from halfword 0
         if (off == 0) begin
            take = 1'b1;
            val = first_hw;
         end else if (off == 1) begin
            take = 1'b1;
         end
      end else if (p[1:0] == align_off) begin
         take = 1'b1;
      end
      if (!take || taken >= limit) return;
      taken = taken + 14'd1;

      x64 = $signed(val);
      prev64 = prev_in;
      y64 = acc_y;
      acc64 = (x64 - prev64) * 64'sd65536;
      mag = (y64 < 0) ? -y64 : y64;
      fb = (mag * {40'd0, cfg_alpha}) >> 24;
      if (y64 < 0) acc64 = acc64 - $signed(fb);
      else acc64 = acc64 + $signed(fb);
      if (acc64 > ACC_TOP) acc64 = ACC_TOP;
      else if (acc64 < ACC_BOTTOM) acc64 = ACC_BOTTOM;
      acc_y = acc64[39:0];
      prev_in = val;

      // Truncate toward zero, then clamp to int16
      mag = (acc64 < 0) ? -acc64 : acc64;
      mag = mag >> 16;
      if (mag > 64'd65536) mag = 64'd65536;
      out64 = (acc64 < 0) ? -$signed(mag) : $signed(mag);
      if (out64 > 32767) out64 = 32767;
      else if (out64 < -32768) out64 = -32768;
      item.sample = out64[15:0];
      item.last = (taken == limit);
      left_samples_due.push_back(item);
   endtask

   task automatic send_beat(input logic [15:0] hw, input logic start, input logic rst);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= hw;
      req_tuser <= {rst, start};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      extract_and_filter(hw, start, rst);
   endtask

   // Hold the sender until every sample is out and the pipeline is empty.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (left_samples_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] len, input logic [23:0] alpha);
      csr_wen <= 1'b1;
      csr_index <= ilxdc_pkg::CSR_BUFFER_HALFWORDS;
      csr_wdata <= {8'd0, len};
      @(posedge clock);
      cfg_len = len;
      csr_index <= ilxdc_pkg::CSR_ALPHA_Q24;
      csr_wdata <= alpha;
      @(posedge clock);
      cfg_alpha = alpha;
      csr_wen <= 1'b0;
   endtask

   function automatic logic [15:0] rand_halfword();
      if ($urandom_range(0, 7) != 0) return 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // Mostly whole buffers; some cut short, some overrun, some stray beats first.
   task automatic send_random_buffer();
      int          n;
      int          form;
      logic [15:0] h0;
      logic [15:0] h1;
      logic [15:0] hw;

      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3))
            send_beat(rand_halfword(), 1'b0, $urandom_range(0, 15) == 0);
      form = $urandom_range(0, 9);
      if (form < 7) n = cfg_len;
      else if (form < 8) n = $urandom_range(1, cfg_len);
      else n = cfg_len + $urandom_range(1, 4);
      h0 = $urandom_range(0, 1) ? 16'd0 : rand_halfword();
      h1 = $urandom_range(0, 1) ? 16'd0 : rand_halfword();
      for (int i = 0; i < n; i++) begin
         hw = (i == 0) ? h0 : (i == 1) ? h1 : rand_halfword();
         send_beat(hw, i == 0,
                   (i == 0) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 31) == 0));
      end
   endtask

   // After reset the first beat counts as halfword 0 without a buffer mark.
   task automatic test_power_on_items();
      send_idle_pct = 0;
      stall_pct = 0;
      send_beat(16'h0001, 1'b0, 1'b0);
      send_beat(16'hFFFF, 1'b0, 1'b0);
      send_beat(16'h8000, 1'b0, 1'b0);
   endtask

   task automatic test_alignment_offsets();
      drain();
      send_idle_pct = 14;
      stall_pct = 14;
      set_config(16'd8, 24'hFFFFFF);
      // both nonzero: offset 0, two samples with a full-scale step
      send_beat(16'h8000, 1'b1, 1'b0);
      send_beat(16'hFFFF, 1'b0, 1'b0);
      send_beat(16'h1234, 1'b0, 1'b0);
      send_beat(16'h0000, 1'b0, 1'b0);
      send_beat(16'h7FFF, 1'b0, 1'b0);
      // zero then nonzero: offset 1, with a restart
      send_beat(16'h0000, 1'b1, 1'b1);
      send_beat(16'h7FFF, 1'b0, 1'b0);
      // both zero: offset 2
      send_beat(16'h0000, 1'b1, 1'b0);
      send_beat(16'h0000, 1'b0, 1'b0);
      send_beat(16'hFFFF, 1'b0, 1'b0);
      // nonzero then zero: offset 3, restart on the sample, then past the limit and end
      send_beat(16'hFFFF, 1'b1, 1'b0);
      send_beat(16'h0000, 1'b0, 1'b0);
      send_beat(16'h5555, 1'b0, 1'b0);
      send_beat(16'h8000, 1'b0, 1'b1);
      send_beat(16'hAAAA, 1'b0, 1'b0);
      send_beat(16'h0001, 1'b0, 1'b0);
      send_beat(16'hFFFE, 1'b0, 1'b0);
      send_beat(16'h7FFE, 1'b0, 1'b0);
      send_beat(16'h8001, 1'b0, 1'b0);
   endtask

   // Limit stays from halfword 1; the end bound follows the new length.
   task automatic test_resize_mid_buffer();
      drain();
      set_config(16'd64, ilxdc_pkg::ALPHA_Q24_RESET);
      send_beat(16'h0001, 1'b1, 1'b0);
      send_beat(16'h0100, 1'b0, 1'b0);
      send_beat(16'hC000, 1'b0, 1'b0);
      send_beat(16'h4000, 1'b0, 1'b0);
      send_beat(16'h2222, 1'b0, 1'b0);
      drain();
      set_config(16'd4, 24'd0);
      send_beat(16'h3333, 1'b0, 1'b0);
      send_beat(16'h4444, 1'b0, 1'b0);
   endtask

   // Largest buffer length: the sample limit comes from the full 16-bit register.
   task automatic test_longest_buffer();
      drain();
      send_idle_pct = 0;
      stall_pct = 0;
      set_config(16'hFFFF, ilxdc_pkg::ALPHA_Q24_RESET);
      for (int i = 0; i < 16; i++)
         send_beat(rand_halfword(), i == 0, 1'b0);
   endtask

   task automatic test_random_traffic();
      int          target;
      logic [15:0] len;
      logic [23:0] alpha;

      target = beats_sent;
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin
               send_idle_pct = 0;  stall_pct = 0;
               len = 16'd4;        alpha = 24'hFFFFFF;
            end
            1: begin
               send_idle_pct = 71; stall_pct = 0;
               len = 16'($urandom_range(5, 24)); alpha = 24'd0;
            end
            2: begin
               send_idle_pct = 0;  stall_pct = 71;
               len = 16'($urandom_range(5, 24)); alpha = 24'($urandom_range(0, 24'hFFFFFF));
            end
            default: begin
               send_idle_pct = 14; stall_pct = 14;
               len = 16'($urandom_range(5, 40)); alpha = ilxdc_pkg::ALPHA_Q24_RESET;
            end
         endcase
         set_config(len, alpha);
         target += 95;
         while (beats_sent < target) send_random_buffer();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_on_items();
      test_alignment_offsets();
      test_resize_mid_buffer();
      test_longest_buffer();
      test_random_traffic();
      drain();
      fault_count += left_samples_due.size();
      if (fault_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
